[rtl/mfpwm_pkg.sv]
// ----------------------------------------------------------------------------
// mfpwm_pkg
// Shared widths, codes and types for the multichannel fading PWM core.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpwm_pkg;

  // Number of LED channels and width of the emitted on-mask.
  localparam int CHANNELS = 5;
  localparam int MASK_W   = 5;
  // Channels that can actually appear in the mask.
  localparam int MASK_CH  = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  localparam int OP_W    = 2;
  localparam int CH_W    = 3;
  localparam int LVL_W   = 8;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_SET_GOAL   = 2'd1,
    OP_SET_DIRECT = 2'd2
  } mfpwm_op_t;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_TOTAL_LEVEL  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_FADE_DIVIDER = 2'd1;

  // Register values after reset.
  localparam logic [LVL_W-1:0] TOTAL_LEVEL_RST  = 8'd255;
  localparam logic [LVL_W-1:0] FADE_DIVIDER_RST = 8'd3;

  // Decoded command issued when the input stage hands off its item.
  typedef struct packed {
    logic             tick;
    logic             set_goal;
    logic             set_direct;
    logic [CH_W-1:0]  channel;
    logic [LVL_W-1:0] level;
  } mfpwm_cmd_t;

  // Timebase status for the channel bank.
  typedef struct packed {
    logic [LVL_W-1:0] phase;
    logic             fade_step;
  } mfpwm_time_t;

endpackage

`default_nettype wire

[rtl/mfpwm_ifs.sv]
// ----------------------------------------------------------------------------
// mfpwm interfaces
// Valid/ready channels for commands, on-mask results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfpwm_in_if import mfpwm_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [CH_W-1:0]  channel;
  logic [LVL_W-1:0] level;

  modport source (output valid, operation, channel, level, input ready);
  modport sink   (input valid, operation, channel, level, output ready);
endinterface

interface mfpwm_out_if import mfpwm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] on_mask;

  modport source (output valid, on_mask, input ready);
  modport sink   (input valid, on_mask, output ready);
endinterface

interface mfpwm_cfg_if import mfpwm_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] index;
  logic [CFG_D_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/mfpwm_timebase.sv]
// ----------------------------------------------------------------------------
// mfpwm_timebase
// Configuration registers, PWM phase counter and fade prescaler.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpwm_timebase import mfpwm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  mfpwm_cfg_if.sink    cfg,
  input  mfpwm_cmd_t   cmd,
  output mfpwm_time_t  tb
);

  logic [LVL_W-1:0] total_r;
  logic [LVL_W-1:0] fade_div_r;
  logic [LVL_W-1:0] phase_r;
  logic [LVL_W-1:0] fade_cnt_r;
  logic [LVL_W-1:0] phase_nxt;
  logic [LVL_W-1:0] fade_cnt_nxt;
  logic [LVL_W:0]   phase_inc;
  logic [LVL_W:0]   fade_inc;
  logic             phase_wrap;
  logic             fade_wrap;

  assign cfg.ready = 1'b1;

  // Both counters compare one bit wider so a limit of 255 still counts 256.
  always_comb begin
    phase_inc    = {1'b0, phase_r} + {{LVL_W{1'b0}}, 1'b1};
    fade_inc     = {1'b0, fade_cnt_r} + {{LVL_W{1'b0}}, 1'b1};
    phase_wrap   = phase_inc > {1'b0, total_r};
    fade_wrap    = fade_inc > {1'b0, fade_div_r};
    phase_nxt    = phase_wrap ? '0 : phase_inc[LVL_W-1:0];
    fade_cnt_nxt = fade_wrap ? '0 : fade_inc[LVL_W-1:0];
  end

  assign tb.phase     = phase_r;
  assign tb.fade_step = cmd.tick && fade_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_LEVEL_RST;
      fade_div_r <= FADE_DIVIDER_RST;
      phase_r    <= '0;
      fade_cnt_r <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TOTAL_LEVEL:  total_r    <= cfg.data;
          CFG_FADE_DIVIDER: fade_div_r <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.tick) begin
        phase_r    <= phase_nxt;
        fade_cnt_r <= fade_cnt_nxt;
      end
    end
  end

  // A fade step always restarts the prescaler.
  a_fade_restart: assert property (@(posedge clk) disable iff (!rst_n)
    tb.fade_step |=> fade_cnt_r == '0)
    else $error("fade counter did not restart after a fade step");

  // A tick that does not wrap advances the phase by exactly one.
  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick && !phase_wrap |=> phase_r == $past(phase_r) + 8'd1)
    else $error("phase did not advance by one on a tick");

  // Without a tick neither counter moves.
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.tick |=> $stable(phase_r) && $stable(fade_cnt_r))
    else $error("timebase moved without a tick");

endmodule

`default_nettype wire

[rtl/mfpwm_channels.sv]
// ----------------------------------------------------------------------------
// mfpwm_channels
// Per-channel current and goal levels, fade stepping and on-mask compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpwm_channels import mfpwm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  mfpwm_cmd_t        cmd,
  input  mfpwm_time_t       tb,
  output logic [MASK_W-1:0] mask
);

  logic [LVL_W-1:0] cur_r  [CHANNELS];
  logic [LVL_W-1:0] goal_r [CHANNELS];

  // A channel is lit while the phase is nonzero and not above its level.
  always_comb begin
    mask = '0;
    for (int c = 0; c < MASK_CH; c++) begin
      mask[c] = (tb.phase != '0) && (tb.phase <= cur_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cur_r[c]  <= '0;
        goal_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if ((cmd.set_goal || cmd.set_direct) && (int'(cmd.channel) == c)) begin
          goal_r[c] <= cmd.level;
          if (cmd.set_direct) begin
            cur_r[c] <= cmd.level;
          end
        end else if (tb.fade_step) begin
          if (cur_r[c] < goal_r[c]) begin
            cur_r[c] <= cur_r[c] + 8'd1;
          end else if (cur_r[c] > goal_r[c]) begin
            cur_r[c] <= cur_r[c] - 8'd1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/multichannel_fading_pwm_core.sv]
// ----------------------------------------------------------------------------
// multichannel_fading_pwm_core
// Multichannel LED PWM with per-channel fade ramps toward a goal level.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the in_ch channel, one per beat: a tick, a set-goal or a
// set-direct for one channel. Each tick produces one beat on out_ch carrying
// the on-mask for that PWM phase; set commands and the unused operation code
// produce no beat. Register writes on cfg_ch (total level, fade divider) are
// always accepted and should be issued only while the core is idle.
// A command is captured in an input register and then decoded and applied
// in a single pass: the mask of a tick is loaded into the output register
// when the tick leaves the input register, and its beat is presented on
// out_ch from the output register until it is taken.
// Throughput is one command per cycle; the only limit is the output register,
// which a tick may enter only when it is empty or being drained that cycle.
// When the receiver stalls, the output register holds its beat and one more
// command waits in the input register; after that in_ch.ready drops. Set
// commands still pass the input stage during a stall since they emit nothing.
// A synchronous reset clears all levels, goals and counters, reloads the
// registers with their defaults and empties both pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_fading_pwm_core import mfpwm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfpwm_in_if.sink   in_ch,
  mfpwm_out_if.source out_ch,
  mfpwm_cfg_if.sink  cfg_ch
);

  // Input register.
  logic              in_vld_r;
  logic [OP_W-1:0]   op_r;
  logic [CH_W-1:0]   ch_r;
  logic [LVL_W-1:0]  lvl_r;

  // Output register.
  logic              out_vld_r;
  logic [MASK_W-1:0] on_mask_r;

  logic              is_tick;
  logic              out_free;
  logic              advance;
  mfpwm_cmd_t        cmd;
  mfpwm_time_t       tb;
  logic [MASK_W-1:0] mask;

  // Decode the held command. Only a tick needs room in the output register.
  always_comb begin
    is_tick  = (op_r == OP_TICK);
    out_free = !out_vld_r || out_ch.ready;
    advance  = in_vld_r && (!is_tick || out_free);

    cmd            = '0;
    cmd.channel    = ch_r;
    cmd.level      = lvl_r;
    if (advance) begin
      case (op_r)
        OP_TICK:       cmd.tick       = 1'b1;
        OP_SET_GOAL:   cmd.set_goal   = 1'b1;
        OP_SET_DIRECT: cmd.set_direct = 1'b1;
        default: ;
      endcase
    end
  end

  assign in_ch.ready    = !in_vld_r || advance;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.on_mask = on_mask_r;

  mfpwm_timebase u_timebase (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cmd   (cmd),
    .tb    (tb)
  );

  mfpwm_channels u_channels (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .tb    (tb),
    .mask  (mask)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end

      if (cmd.tick) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.operation;
      ch_r  <= in_ch.channel;
      lvl_r <= in_ch.level;
    end
    if (cmd.tick) begin
      on_mask_r <= mask;
    end
  end

endmodule

`default_nettype wire

[sim/tb_multichannel_fading_pwm_core.sv]
// ----------------------------------------------------------------------------
// tb_multichannel_fading_pwm_core
// Self-checking bench for the multichannel fading PWM core. Commands are
// pushed through the input channel by a clocked driver. Each accepted beat
// advances a bench-side copy of the levels, goals and counters, and every
// tick queues its expected on-mask. A clocked monitor drains the result
// channel under random back-pressure and compares each beat in order.
// ----------------------------------------------------------------------------
module tb_multichannel_fading_pwm_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mfpwm_pkg::*;

  // Operation code that the core must ignore. It has no member in the package enum.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Watchdog limit. It leaves a wide margin over a correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Set commands leave no trace on the result channel, so this many quiet
  // cycles are allowed before a register write.
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [LVL_W-1:0] lv;
  } pwm_cmd_t;

  logic clk;
  logic rst_n;

  mfpwm_in_if  in_if ();
  mfpwm_out_if out_if ();
  mfpwm_cfg_if cfg_if ();

  multichannel_fading_pwm_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Commands that are waiting for the driver, and on-masks that are waiting
  // for the monitor.
  pwm_cmd_t          cmd_pending[$];
  logic [MASK_W-1:0] mask_expected[$];

  // Bench copy of the core's registers and state.
  logic [LVL_W-1:0] total_level_q;
  logic [LVL_W-1:0] fade_divider_q;
  logic [LVL_W-1:0] phase_q;
  logic [LVL_W-1:0] fade_count_q;
  logic [LVL_W-1:0] level_now[CHANNELS];
  logic [LVL_W-1:0] level_goal[CHANNELS];

  // Idle and stall rates, in percent, on each side of the core.
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned tick_count;
  int unsigned set_count;
  int unsigned ignored_count;
  int unsigned result_count;
  int unsigned cfg_count;

  logic [MASK_W-1:0] mask_want;

  always #4 clk = ~clk;

  // Every mismatch ends up here. The run keeps going so that all failures show.
  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // Advance the bench copy by one accepted command. A tick forms the mask from
  // the phase as it stood before this tick. Then the fade counter moves, and
  // after it the phase. Both compares are done at 9 bits, so a divider of 255
  // gives one step every 256 ticks. A phase that is left above a lowered total
  // level also wraps on its next tick.
  function automatic void pwm_advance(input pwm_cmd_t cmd);
    logic [MASK_W-1:0] mask;
    logic [LVL_W:0]    nxt;
    mask = '0;
    case (cmd.op)
      OP_SET_GOAL, OP_SET_DIRECT: begin
        // Channel numbers past the last channel are dropped without effect.
        if (cmd.ch < CHANNELS) begin
          level_goal[cmd.ch] = cmd.lv;
          if (cmd.op == OP_SET_DIRECT) level_now[cmd.ch] = cmd.lv;
          set_count++;
        end else begin
          ignored_count++;
        end
      end
      OP_TICK: begin
        for (int c = 0; c < MASK_CH; c++) begin
          if (phase_q != 0 && phase_q <= level_now[c]) mask[c] = 1'b1;
        end
        nxt = {1'b0, fade_count_q} + 1'b1;
        if (nxt > {1'b0, fade_divider_q}) begin
          fade_count_q = '0;
          for (int c = 0; c < CHANNELS; c++) begin
            if (level_now[c] < level_goal[c]) level_now[c] = level_now[c] + 1'b1;
            else if (level_now[c] > level_goal[c]) level_now[c] = level_now[c] - 1'b1;
          end
        end else begin
          fade_count_q = nxt[LVL_W-1:0];
        end
        nxt = {1'b0, phase_q} + 1'b1;
        phase_q = (nxt > {1'b0, total_level_q}) ? '0 : nxt[LVL_W-1:0];
        mask_expected.push_back(mask);
        tick_count++;
      end
      default: ignored_count++;
    endcase
  endfunction

  // Driver. A beat is predicted at the edge where it is accepted. The bus is
  // then loaded again, or dropped for an idle cycle. Valid gets at most one
  // nonblocking write per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pwm_advance('{op: in_if.operation, ch: in_if.channel, lv: in_if.level});
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          pwm_cmd_t nxt_cmd;
          nxt_cmd = cmd_pending.pop_front();
          in_if.valid     <= 1'b1;
          in_if.operation <= nxt_cmd.op;
          in_if.channel   <= nxt_cmd.ch;
          in_if.level     <= nxt_cmd.lv;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result beat is matched against the oldest queued mask. Ready
  // is redrawn on every edge, so stalls hit every point of the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        result_count++;
        if (mask_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected on_mask beat %b", out_if.on_mask));
        end else begin
          mask_want = mask_expected.pop_front();
          if (out_if.on_mask !== mask_want)
            report_mismatch($sformatf("on_mask %b, expected %b", out_if.on_mask, mask_want));
        end
      end
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d masks outstanding",
               cycle_count, mask_expected.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Wait until the driver is empty and all masks are in. Then give any set
  // command still in the pipeline time to land.
  task automatic wait_quiet();
    do @(posedge clk);
    while (cmd_pending.size() != 0 || in_if.valid || mask_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write over the configuration channel. It is only called while
  // the core is quiet, so the bench copy can take the new value at once.
  task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_TOTAL_LEVEL) total_level_q = val;
    else if (idx == CFG_FADE_DIVIDER) fade_divider_q = val;
    cfg_count++;
  endtask

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                          input logic [LVL_W-1:0] lv);
    cmd_pending.push_back('{op: op, ch: ch, lv: lv});
  endtask

  // Random traffic. Most beats are ticks, so that the phase and the fades run
  // through their full cycles. Set commands land in the mix, and now and then
  // an unused code or an out-of-range channel shows up. Half of the levels
  // are drawn within the current PWM period, so the masks come out mixed.
  task automatic push_random(input int unsigned count);
    int unsigned pick;
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [LVL_W-1:0] lv;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 62) op = OP_TICK;
      else if (pick < 78) op = OP_SET_GOAL;
      else if (pick < 95) op = OP_SET_DIRECT;
      else op = OP_UNUSED;
      if ($urandom_range(9) == 0) ch = CH_W'($urandom_range(7, CHANNELS));
      else ch = CH_W'($urandom_range(CHANNELS - 1, 0));
      if ($urandom_range(1) == 0) lv = LVL_W'($urandom_range(total_level_q, 0));
      else lv = LVL_W'($urandom_range(255, 0));
      push_cmd(op, ch, lv);
    end
  endtask

  // One phase: new register values while the core is quiet, new traffic rates,
  // then a batch of random commands.
  task automatic run_phase(input logic [LVL_W-1:0] tot, input logic [LVL_W-1:0] div,
                           input int unsigned idle_pct, input int unsigned count);
    wait_quiet();
    cfg_write(CFG_TOTAL_LEVEL, tot);
    cfg_write(CFG_FADE_DIVIDER, div);
    in_idle_pct   = idle_pct;
    out_stall_pct = idle_pct;
    push_random(count);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_TICK;
    in_if.channel   = '0;
    in_if.level     = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_TOTAL_LEVEL;
    cfg_if.data     = '0;
    cycle_count     = 0;
    err_count       = 0;
    tick_count      = 0;
    set_count       = 0;
    ignored_count   = 0;
    result_count    = 0;
    cfg_count       = 0;
    in_idle_pct     = 37;
    out_stall_pct   = 37;

    // State after reset: defaults in both registers, everything else zero.
    total_level_q  = TOTAL_LEVEL_RST;
    fade_divider_q = FADE_DIVIDER_RST;
    phase_q        = '0;
    fade_count_q   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      level_now[c]  = '0;
      level_goal[c] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset defaults. Levels go to the extremes,
    // goals are set to pull them the other way, and the unused code and
    // channel numbers past the last channel must be ignored. The ticks that
    // follow then show the first phases and the first fade step.
    push_cmd(OP_SET_DIRECT, 3'd0, 8'd255);
    push_cmd(OP_SET_DIRECT, 3'd1, 8'd0);
    push_cmd(OP_SET_DIRECT, 3'd2, 8'd1);
    push_cmd(OP_SET_DIRECT, 3'd3, 8'd128);
    push_cmd(OP_SET_DIRECT, 3'd4, 8'd254);
    push_cmd(OP_SET_GOAL,   3'd0, 8'd0);
    push_cmd(OP_SET_GOAL,   3'd1, 8'd255);
    push_cmd(OP_SET_GOAL,   3'd4, 8'd255);
    push_cmd(OP_UNUSED,     3'd2, 8'd0);
    push_cmd(OP_SET_DIRECT, 3'd5, 8'd77);
    push_cmd(OP_SET_GOAL,   3'd7, 8'd255);
    push_cmd(OP_SET_DIRECT, 3'd6, 8'd170);
    for (int n = 0; n < 10; n++) push_cmd(OP_TICK, 3'd7, 8'd255);
    push_cmd(OP_SET_GOAL,   3'd2, 8'd2);
    push_random(230);

    // Several register settings, including both extremes of the fade divider.
    // Going from a long period to a short one leaves the phase above the new
    // total level, which must wrap on the next tick. The third phase runs with
    // no idling on either side.
    run_phase(8'd1,   8'd0,   37, 255);
    run_phase(8'd255, 8'd255, 37, 255);
    run_phase(8'd7,   8'd1,   0,  255);
    run_phase(LVL_W'($urandom_range(255, 1)), LVL_W'($urandom_range(255, 0)), 37, 255);
    run_phase(8'd128, 8'd0,   37, 255);
    wait_quiet();

    if (mask_expected.size() != 0)
      report_mismatch($sformatf("%0d masks never arrived", mask_expected.size()));

    $display("Covered %0d ticks, %0d set commands, %0d ignored commands, %0d register writes.",
             tick_count, set_count, ignored_count, cfg_count);
    $display("Checked %0d on-mask beats in %0d cycles, %0d mismatches.",
             result_count, cycle_count, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
